// ===== rtl/pctd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pctd_pkg - shared types and constants of the prefix code tree decoder
// Command codes, status codes, character codes and the queue entry format.
// ----------------------------------------------------------------------------
package pctd_pkg;

    localparam int CODE_BITS_W   = 4;
    localparam int CODE_LEN_W    = 3;
    localparam int SYM_PORT_W    = 8;
    localparam int CHAR_W        = 8;
    localparam int STATUS_W      = 2;

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;  // '0'
    localparam logic [CHAR_W-1:0] CHAR_ONE     = 8'h31;  // '1'
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;  // '\n'

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BADCHAR = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOPATH  = 2'd2;

    typedef logic [1:0] op_t;
    localparam op_t OP_INS  = 2'd0;  // add a code path
    localparam op_t OP_STEP = 2'd1;  // one tree step
    localparam op_t OP_BAD  = 2'd2;  // character that is not a bit

    typedef struct packed {
        op_t                   op;
        logic                  step_bit;
        logic [CODE_BITS_W-1:0] code_bits;
        logic [CODE_LEN_W-1:0]  code_length;
        logic [SYM_PORT_W-1:0]  symbol;
    } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/prefix_code_tree_decoder_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prefix_code_tree_decoder_unit - binary prefix code tree decoder
// Input items either add a code path (mode 0) or feed one message character
// (mode 1). Result items carry a decoded symbol index or an error status.
// Usage:
//  - s_* is the item input, m_* the result output, both valid/ready.
//  - An accepted item is registered in the queue before the engine takes it.
//  - Load items: the engine takes the item, then marks the path's nodes one
//    level per cycle. No result.
//  - Decode items: one tree step per cycle while the result register is free
//    and no leaf is read. Once the tree holds a path, a bad character or a
//    missing node gives a result in the cycle after the engine takes the
//    item; a leaf's result goes through the registered symbol read and the
//    ST_SYM state. Inner nodes give no result; newlines drop at the input.
//  - A two-entry queue lets s_ready stay high while the engine works.
//  - While a result waits with m_ready low, the result register holds; the
//    engine waits and the queue fills, then s_ready drops.
//  - Reset (aresetn low, synchronous) leaves only the root present and the
//    decode position at the root. Symbol storage is not cleared.
// ----------------------------------------------------------------------------
module prefix_code_tree_decoder_unit #(
    parameter int MAX_CODE_BITS = 4,
    parameter int SYMBOL_WIDTH  = 8
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_mode,
    input  wire logic [pctd_pkg::CODE_BITS_W-1:0]   s_code_bits,
    input  wire logic [pctd_pkg::CODE_LEN_W-1:0]    s_code_length,
    input  wire logic [pctd_pkg::SYM_PORT_W-1:0]    s_symbol,
    input  wire logic [pctd_pkg::CHAR_W-1:0]        s_bit_char,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [pctd_pkg::SYM_PORT_W-1:0]         m_decoded_symbol,
    output logic [pctd_pkg::STATUS_W-1:0]           m_status
);
    import pctd_pkg::*;

    logic q_full;
    logic q_push;
    cmd_t q_push_cmd;
    logic q_pop;
    logic q_valid;
    cmd_t q_head_cmd;

    // front: accept and classify
    pctd_front #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_code_bits   (s_code_bits),
        .s_code_length (s_code_length),
        .s_symbol      (s_symbol),
        .s_bit_char    (s_bit_char),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (q_push_cmd)
    );

    // decoupling queue
    pctd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head_cmd (q_head_cmd)
    );

    // back: tree storage, walk and result register
    pctd_back #(
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .SYMBOL_WIDTH  (SYMBOL_WIDTH)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (q_valid),
        .q_cmd            (q_head_cmd),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_decoded_symbol (m_decoded_symbol),
        .m_status         (m_status)
    );

endmodule
`default_nettype wire

// ===== rtl/pctd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pctd_front - input item classifier
// Accepts items while the queue has room, drops ignored items and turns the
// rest into queue commands.
// ----------------------------------------------------------------------------
module pctd_front #(
    parameter int MAX_CODE_BITS = 4
) (
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_mode,
    input  wire logic [pctd_pkg::CODE_BITS_W-1:0] s_code_bits,
    input  wire logic [pctd_pkg::CODE_LEN_W-1:0]  s_code_length,
    input  wire logic [pctd_pkg::SYM_PORT_W-1:0]  s_symbol,
    input  wire logic [pctd_pkg::CHAR_W-1:0]      s_bit_char,
    input  wire logic                           q_full,
    output logic                                q_push,
    output pctd_pkg::cmd_t                      q_cmd
);
    import pctd_pkg::*;

    logic keep;
    logic len_ok;

    // lengths of zero or beyond the tree depth are ignored
    assign len_ok = (s_code_length != '0) && (int'(s_code_length) <= MAX_CODE_BITS);

    always_comb begin
        q_cmd.step_bit    = (s_bit_char == CHAR_ONE);
        q_cmd.code_bits   = s_code_bits;
        q_cmd.code_length = s_code_length;
        q_cmd.symbol      = s_symbol;
        if (!s_mode) begin
            q_cmd.op = OP_INS;
            keep     = len_ok;
        end else if (s_bit_char == CHAR_ZERO || s_bit_char == CHAR_ONE) begin
            q_cmd.op = OP_STEP;
            keep     = 1'b1;
        end else begin
            q_cmd.op = OP_BAD;
            keep     = (s_bit_char != CHAR_NEWLINE);  // newlines vanish here
        end
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready && keep;

endmodule
`default_nettype wire

// ===== rtl/pctd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pctd_queue - two-entry command queue
// Decouples the classifier from the tree engine.
// ----------------------------------------------------------------------------
module pctd_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire pctd_pkg::cmd_t push_cmd,
    output logic                full,
    input  wire logic           pop,
    output logic                valid,
    output pctd_pkg::cmd_t      head_cmd
);
    import pctd_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign valid    = (count_reg != 2'd0);
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/pctd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pctd_back - tree engine
// Holds the heap of node marks and the symbol memory, walks code paths for
// loads and takes one tree step per decode command. Owns the result register.
// ----------------------------------------------------------------------------
module pctd_back #(
    parameter int MAX_CODE_BITS = 4,
    parameter int SYMBOL_WIDTH  = 8
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              q_valid,
    input  wire pctd_pkg::cmd_t                    q_cmd,
    output logic                                   q_pop,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [pctd_pkg::SYM_PORT_W-1:0]        m_decoded_symbol,
    output logic [pctd_pkg::STATUS_W-1:0]          m_status
);
    import pctd_pkg::*;

    localparam int NW   = MAX_CODE_BITS + 1;
    localparam int HEAP = 1 << NW;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_INS  = 2'd1;
    localparam logic [1:0] ST_SYM  = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic [HEAP-1:0]         node_present_reg, node_present_next;
    logic [HEAP-1:0]         node_child_reg, node_child_next;   // has a present child
    logic [NW-1:0]           cur_reg, cur_next;
    logic [NW-1:0]           ins_node_reg, ins_node_next;
    logic [CODE_LEN_W-1:0]   ins_pos_reg, ins_pos_next;
    logic [CODE_BITS_W-1:0]  ins_bits_reg, ins_bits_next;
    logic [SYM_PORT_W-1:0]   ins_sym_reg, ins_sym_next;
    logic                    m_valid_reg, m_valid_next;
    logic [SYM_PORT_W-1:0]   m_sym_reg, m_sym_next;
    logic [STATUS_W-1:0]     m_status_reg, m_status_next;

    logic [SYMBOL_WIDTH-1:0] sym_mem [HEAP];
    logic [SYMBOL_WIDTH-1:0] sym_rd_reg;
    logic                    mem_we, mem_re;
    logic [NW-1:0]           mem_waddr, mem_raddr;
    logic [SYMBOL_WIDTH-1:0] mem_wdata;

    logic                    out_free;
    logic                    ins_bit;
    logic [NW-1:0]           ins_child;
    logic [NW-1:0]           step_idx;
    logic                    step_fall_off;
    logic [SYMBOL_WIDTH+SYM_PORT_W-1:0] sym_wide_in;
    logic [SYMBOL_WIDTH+SYM_PORT_W-1:0] sym_wide_out;

    assign out_free = !m_valid_reg || m_ready;

    // bit of the code path at the current position, zero above the port width
    assign ins_bit   = (ins_pos_reg < CODE_LEN_W'(CODE_BITS_W)) ?
                       ins_bits_reg[ins_pos_reg[1:0]] : 1'b0;
    assign ins_child = {ins_node_reg[NW-2:0], ins_bit};

    // a node on the deepest level has no child slots
    assign step_fall_off = cur_reg[NW-1];
    assign step_idx      = {cur_reg[NW-2:0], q_cmd.step_bit};

    assign sym_wide_in  = {{SYMBOL_WIDTH{1'b0}}, ins_sym_reg};
    assign sym_wide_out = {{SYM_PORT_W{1'b0}}, sym_rd_reg};
    assign mem_wdata    = sym_wide_in[SYMBOL_WIDTH-1:0];
    assign mem_waddr    = ins_child;
    assign mem_raddr    = step_idx;

    always_comb begin
        state_next        = state_reg;
        node_present_next = node_present_reg;
        node_child_next   = node_child_reg;
        cur_next          = cur_reg;
        ins_node_next     = ins_node_reg;
        ins_pos_next      = ins_pos_reg;
        ins_bits_next     = ins_bits_reg;
        ins_sym_next      = ins_sym_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_sym_next        = m_sym_reg;
        m_status_next     = m_status_reg;
        q_pop             = 1'b0;
        mem_we            = 1'b0;
        mem_re            = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop = 1'b1;
                    case (q_cmd.op)
                        OP_INS: begin
                            ins_node_next = NW'(1);
                            ins_pos_next  = q_cmd.code_length - CODE_LEN_W'(1);
                            ins_bits_next = q_cmd.code_bits;
                            ins_sym_next  = q_cmd.symbol;
                            state_next    = ST_INS;
                        end
                        OP_BAD: begin
                            if (node_child_reg[1]) begin
                                m_valid_next  = 1'b1;
                                m_sym_next    = '0;
                                m_status_next = STATUS_BADCHAR;
                            end
                        end
                        OP_STEP: begin
                            // empty tree: decode items vanish
                            if (node_child_reg[1]) begin
                                if (step_fall_off || !node_present_reg[step_idx]) begin
                                    cur_next      = NW'(1);
                                    m_valid_next  = 1'b1;
                                    m_sym_next    = '0;
                                    m_status_next = STATUS_NOPATH;
                                end else if (node_child_reg[step_idx]) begin
                                    cur_next = step_idx;
                                end else begin
                                    cur_next   = NW'(1);
                                    mem_re     = 1'b1;
                                    state_next = ST_SYM;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_INS: begin
                node_present_next[ins_child]  = 1'b1;
                node_child_next[ins_node_reg] = 1'b1;
                ins_node_next                 = ins_child;
                if (ins_pos_reg == '0) begin
                    mem_we     = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    ins_pos_next = ins_pos_reg - CODE_LEN_W'(1);
                end
            end
            ST_SYM: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_sym_next    = sym_wide_out[SYM_PORT_W-1:0];
                    m_status_next = STATUS_OK;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            node_present_reg <= HEAP'(2);   // root only
            node_child_reg   <= '0;
            cur_reg          <= NW'(1);
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            node_present_reg <= node_present_next;
            node_child_reg   <= node_child_next;
            cur_reg          <= cur_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ins_node_reg <= ins_node_next;
        ins_pos_reg  <= ins_pos_next;
        ins_bits_reg <= ins_bits_next;
        ins_sym_reg  <= ins_sym_next;
        m_sym_reg    <= m_sym_next;
        m_status_reg <= m_status_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            sym_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            sym_rd_reg <= sym_mem[mem_raddr];
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_decoded_symbol = m_sym_reg;
    assign m_status         = m_status_reg;

endmodule
`default_nettype wire
